### rtl/sbn_pkg.sv
package sbn_pkg;

	localparam int STAMP_BITS = 16;

	localparam logic ACT_ARRIVE  = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_FIND   = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_FIN    = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

	typedef struct packed {
		logic ld_in;
		logic dispatch_now;
		logic idx_clr;
		logic idx_inc;
		logic wr_entry;
		logic set_drop;
		logic rd_issue;
		logic finish_rel;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic busy;
		logic slot_free;
		logic idx_last;
	} sts_t;

endpackage

### rtl/sbn_in_if.sv
interface sbn_in_if #(
	parameter int ID_BITS   = 8,
	parameter int TIME_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [ID_BITS-1:0]   proc_id;
	logic [TIME_BITS-1:0] event_time;
	logic [TIME_BITS-1:0] proc_time;

	modport source(output valid, action, proc_id, event_time, proc_time, input ready);
	modport sink(input valid, action, proc_id, event_time, proc_time, output ready);
endinterface

### rtl/sbn_out_if.sv
interface sbn_out_if #(
	parameter int ID_BITS = 8
);
	logic               valid;
	logic               ready;
	logic               dispatch_valid;
	logic [ID_BITS-1:0] dispatch_id;
	logic               dropped;
	logic               cpu_busy_now;

	modport source(output valid, dispatch_valid, dispatch_id, dropped, cpu_busy_now,
		input ready);
	modport sink(input valid, dispatch_valid, dispatch_id, dropped, cpu_busy_now,
		output ready);
endinterface

### rtl/sbn_ctrl.sv
module sbn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  sbn_pkg::sts_t sts,
	output sbn_pkg::cmd_t cmd
);
	import sbn_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.ld_in   = 1'b1;
					cmd.idx_clr = 1'b1;
					if (sts.action == ACT_RELEASE) begin
						state_d = S_SCAN;
					end else if (!sts.busy) begin
						cmd.dispatch_now = 1'b1;
						state_d          = S_RESULT;
					end else begin
						state_d = S_FIND;
					end
				end
			end
			S_FIND: begin
				if (sts.slot_free) begin
					cmd.wr_entry = 1'b1;
					state_d      = S_RESULT;
				end else if (sts.idx_last) begin
					cmd.set_drop = 1'b1;
					state_d      = S_RESULT;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.rd_issue = 1'b1;
				if (sts.idx_last) begin
					state_d = S_DRAIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_DRAIN: begin
				// last entry is compared this cycle
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish_rel = 1'b1;
				state_d        = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/sbn_dp.sv
module sbn_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8,
	parameter int TIME_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbn_pkg::cmd_t        cmd,
	output sbn_pkg::sts_t        sts,
	input  logic                 action,
	input  logic [ID_BITS-1:0]   proc_id,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [TIME_BITS-1:0] proc_time,
	output logic                 dispatch_valid,
	output logic [ID_BITS-1:0]   dispatch_id,
	output logic                 dropped,
	output logic                 cpu_busy_now
);
	import sbn_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int BW    = TIME_BITS + 1;
	localparam int EW    = ID_BITS + BW + STAMP_BITS;

	// request capture
	logic [ID_BITS-1:0]   id_q;
	logic signed [BW-1:0] burst_q;

	logic                   busy_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [STAMP_BITS-1:0]  cnt_q;
	logic [IDX_W-1:0]       idx_q;

	// ready table: {id, burst, stamp}
	logic [EW-1:0] mem [QUEUE_DEPTH];

	// read stage
	logic [EW-1:0]    rd_s1;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             cmp_s1;

	logic [ID_BITS-1:0]    rd_id;
	logic signed [BW-1:0]  rd_burst;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic [STAMP_BITS-1:0] rd_age;
	logic                  better;

	// running best
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic signed [BW-1:0]  best_burst_q;
	logic [STAMP_BITS-1:0] best_age_q;
	logic [ID_BITS-1:0]    best_id_q;

	// result and output registers
	logic               res_dv_q;
	logic [ID_BITS-1:0] res_id_q;
	logic               res_drop_q;
	logic               out_dv_q;
	logic [ID_BITS-1:0] out_id_q;
	logic               out_drop_q;
	logic               out_busy_q;

	assign sts.action    = action;
	assign sts.busy      = busy_q;
	assign sts.slot_free = !valid_q[idx_q];
	assign sts.idx_last  = (idx_q == IDX_W'(QUEUE_DEPTH - 1));

	assign rd_id    = rd_s1[EW-1 -: ID_BITS];
	assign rd_burst = rd_s1[STAMP_BITS +: BW];
	assign rd_stamp = rd_s1[STAMP_BITS-1:0];
	assign rd_age   = cnt_q - rd_stamp;
	// smaller burst wins; ties go to the older entry
	assign better   = !found_q || (rd_burst < best_burst_q) ||
		((rd_burst == best_burst_q) && (rd_age > best_age_q));

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			id_q    <= proc_id;
			burst_q <= $signed({1'b0, event_time}) - $signed({1'b0, proc_time});
		end
		if (cmd.wr_entry) begin
			mem[idx_q] <= {id_q, burst_q, cnt_q};
		end
		if (cmd.rd_issue) begin
			rd_s1     <= mem[idx_q];
			rd_vld_s1 <= valid_q[idx_q];
			rd_idx_s1 <= idx_q;
		end
		if (cmp_s1 && rd_vld_s1 && better) begin
			best_idx_q   <= rd_idx_s1;
			best_burst_q <= rd_burst;
			best_age_q   <= rd_age;
			best_id_q    <= rd_id;
		end
		if (cmd.dispatch_now) begin
			res_dv_q   <= 1'b1;
			res_id_q   <= proc_id;
			res_drop_q <= 1'b0;
		end else if (cmd.wr_entry) begin
			res_dv_q   <= 1'b0;
			res_id_q   <= '0;
			res_drop_q <= 1'b0;
		end else if (cmd.set_drop) begin
			res_dv_q   <= 1'b0;
			res_id_q   <= '0;
			res_drop_q <= 1'b1;
		end else if (cmd.finish_rel) begin
			res_dv_q   <= found_q;
			res_id_q   <= found_q ? best_id_q : '0;
			res_drop_q <= 1'b0;
		end
		if (cmd.out_load) begin
			out_dv_q   <= res_dv_q;
			out_id_q   <= res_id_q;
			out_drop_q <= res_drop_q;
			out_busy_q <= busy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			cmp_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			cmp_s1 <= cmd.rd_issue;
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.ld_in) begin
				found_q <= 1'b0;
			end else if (cmp_s1 && rd_vld_s1) begin
				found_q <= 1'b1;
			end
			if (cmd.dispatch_now) begin
				busy_q <= 1'b1;
			end
			if (cmd.wr_entry) begin
				valid_q[idx_q] <= 1'b1;
				cnt_q          <= cnt_q + 1'b1;
			end
			if (cmd.finish_rel) begin
				busy_q <= found_q;
				if (found_q) begin
					valid_q[best_idx_q] <= 1'b0;
				end
			end
		end
	end

	assign dispatch_valid = out_dv_q;
	assign dispatch_id    = out_id_q;
	assign dropped        = out_drop_q;
	assign cpu_busy_now   = out_busy_q;

endmodule

### rtl/shortest_burst_next_scheduler.sv
// Channel | Dir | Payload                                          | Handshake
// req     | in  | action, proc_id, event_time, proc_time           | valid/ready
// rsp     | out | dispatch_valid, dispatch_id, dropped, cpu_busy_now | valid/ready
//
// One request at a time; exactly one response per request.
// Arrival with CPU idle dispatches directly. Arrival with CPU busy runs the
// one-slot-a-cycle free-slot search and drops the request if no slot is free.
// Release runs the one-entry-a-cycle scan through the ready table's read port.
// Reset clears CPU state, table valid bits and the arrival counter at once.
// A response waiting in the output register does not block the next request;
// a stalled rsp side holds the following result until the register frees.
module shortest_burst_next_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8,
	parameter int TIME_BITS   = 16
) (
	input logic      clk,
	input logic      arst_n,
	sbn_in_if.sink   req,
	sbn_out_if.source rsp
);
	import sbn_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbn_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (req.action),
		.proc_id        (req.proc_id),
		.event_time     (req.event_time),
		.proc_time      (req.proc_time),
		.dispatch_valid (rsp.dispatch_valid),
		.dispatch_id    (rsp.dispatch_id),
		.dropped        (rsp.dropped),
		.cpu_busy_now   (rsp.cpu_busy_now)
	);

endmodule

### rtl/sbn_chk.sv
module sbn_chk #(
	parameter int ID_BITS = 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               dispatch_valid,
	input logic [ID_BITS-1:0] dispatch_id,
	input logic               dropped,
	input logic               cpu_busy_now
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in flight");

	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dispatch_valid |-> dispatch_id == '0)
		else $error("dispatch id nonzero without dispatch");

	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !dispatch_valid && cpu_busy_now)
		else $error("drop with dispatch or idle CPU");

	a_dispatch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dispatch_valid |-> cpu_busy_now)
		else $error("dispatch leaves CPU idle");

endmodule

bind shortest_burst_next_scheduler sbn_chk #(
	.ID_BITS (ID_BITS)
) u_sbn_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.dispatch_valid (rsp.dispatch_valid),
	.dispatch_id    (rsp.dispatch_id),
	.dropped        (rsp.dropped),
	.cpu_busy_now   (rsp.cpu_busy_now)
);
